/* src/vmes_pkg.sv */
// Shared types, codes and decode tables for the evaluation stack unit.
// No dependencies; used by every module of the block but vmes_ram.
package vmes_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam logic [8:0] LIMIT_RESET = 9'd256;

    typedef enum logic [3:0] {
        F_PUSH  = 4'd0,
        F_DEPTH = 4'd1,
        F_DROP  = 4'd2,
        F_NIP   = 4'd3,
        F_XDROP = 4'd4,
        F_CLEAR = 4'd5,
        F_DUP   = 4'd6,
        F_OVER  = 4'd7,
        F_PICK  = 4'd8,
        F_TUCK  = 4'd9,
        F_SWAP  = 4'd10,
        F_ROT   = 4'd11,
        F_ROLL  = 4'd12,
        F_REV3  = 4'd13,
        F_REV4  = 4'd14,
        F_REVN  = 4'd15
    } t_func;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_NEG   = 3'd2,
        ST_RANGE = 3'd3,
        ST_OVER  = 3'd4
    } t_status;

    // operation class, picks the execution sequence
    typedef enum logic [2:0] {
        CL_FIXED = 3'd0,
        CL_PICK  = 3'd1,
        CL_XDROP = 3'd2,
        CL_ROLL  = 3'd3,
        CL_REV   = 3'd4
    } t_cls;

    // data source of one fixed-shape write slot
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_PV   = 3'd1,
        SRC_CNT  = 3'd2,
        SRC_W0   = 3'd3,
        SRC_W1   = 3'd4,
        SRC_W2   = 3'd5,
        SRC_W3   = 3'd6
    } t_src;

    typedef enum logic [2:0] {
        RD_LOAD  = 3'd0,
        RD_IDX   = 3'd1,
        RD_PNEXT = 3'd2,
        RD_LO    = 3'd3,
        RD_HI    = 3'd4,
        RD_TOP   = 3'd5
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_SLOT = 3'd0,
        WR_PICK = 3'd1,
        WR_MOVE = 3'd2,
        WR_ROLL = 3'd3,
        WR_LO   = 3'd4,
        WR_HI   = 3'd5
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        t_rd_sel rd_sel;
        logic    we;
        t_wr_sel wr_sel;
        logic [2:0] step;
        logic    cap_w;
        logic    cap_tmp;
        logic    init;
        logic    mv_step;
        logic    rv_step;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        logic err;
        t_cls cls;
        logic mv_done;
        logic rev_done;
    } t_sts;

    // words an opcode needs on the stack
    function automatic logic [2:0] need_cnt(input t_func f);
        logic [2:0] r;
        unique case (f)
            F_PUSH, F_DEPTH, F_CLEAR:                     r = 3'd0;
            F_DROP, F_XDROP, F_DUP, F_PICK, F_ROLL, F_REVN: r = 3'd1;
            F_NIP, F_OVER, F_TUCK, F_SWAP:                r = 3'd2;
            F_ROT, F_REV3:                                r = 3'd3;
            F_REV4:                                       r = 3'd4;
            default:                                      r = 3'd0;
        endcase
        return r;
    endfunction

    // slot j writes address count-4+j; W0 is the old top word
    function automatic t_src slot_src(input t_func f, input logic [2:0] j);
        t_src r;
        r = SRC_NONE;
        unique case (f)
            F_PUSH:  if (j == 3'd4) r = SRC_PV;
            F_DEPTH: if (j == 3'd4) r = SRC_CNT;
            F_DUP:   if (j == 3'd4) r = SRC_W0;
            F_OVER:  if (j == 3'd4) r = SRC_W1;
            F_TUCK: begin
                if (j == 3'd2 || j == 3'd4) r = SRC_W0;
                else if (j == 3'd3) r = SRC_W1;
            end
            F_NIP:   if (j == 3'd2) r = SRC_W0;
            F_SWAP: begin
                if (j == 3'd2) r = SRC_W0;
                else if (j == 3'd3) r = SRC_W1;
            end
            F_ROT: begin
                if (j == 3'd1) r = SRC_W1;
                else if (j == 3'd2) r = SRC_W0;
                else if (j == 3'd3) r = SRC_W2;
            end
            F_REV3: begin
                if (j == 3'd1) r = SRC_W0;
                else if (j == 3'd3) r = SRC_W2;
            end
            F_REV4: begin
                if (j == 3'd0) r = SRC_W0;
                else if (j == 3'd1) r = SRC_W1;
                else if (j == 3'd2) r = SRC_W2;
                else if (j == 3'd3) r = SRC_W3;
            end
            default: r = SRC_NONE;
        endcase
        return r;
    endfunction

endpackage

/* src/vmes_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vmes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* src/vmes_ctrl.sv */
// Sequencer of the evaluation stack unit: walks each opcode through load,
// check, execute and top-word read. Depends on vmes_pkg.
module vmes_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  vmes_pkg::t_sts  i_sts,
    output vmes_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'd1 << 0,
        S_LOAD   = 17'd1 << 1,
        S_CHECK  = 17'd1 << 2,
        S_SLOT   = 17'd1 << 3,
        S_PK_RD  = 17'd1 << 4,
        S_PK_WR  = 17'd1 << 5,
        S_RL_RD  = 17'd1 << 6,
        S_RL_CAP = 17'd1 << 7,
        S_MV_RD  = 17'd1 << 8,
        S_MV_WR  = 17'd1 << 9,
        S_RL_WR  = 17'd1 << 10,
        S_RV_RA  = 17'd1 << 11,
        S_RV_RB  = 17'd1 << 12,
        S_RV_WA  = 17'd1 << 13,
        S_RV_WB  = 17'd1 << 14,
        S_FIN    = 17'd1 << 15,
        S_OUT    = 17'd1 << 16
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_step, n_step;
    vmes_pkg::t_cls  r_cls, n_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_cls   <= vmes_pkg::CL_FIXED;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cls   <= n_cls;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        n_cls   = r_cls;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                    n_step       = 3'd0;
                end
            end
            S_LOAD: begin
                // four top words read back to back, each captured in the next cycle
                o_cmd.rd_sel = vmes_pkg::RD_LOAD;
                o_cmd.step   = r_step;
                o_cmd.cap_w  = (r_step != 3'd0);
                if (r_step == 3'd4) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_CHECK: begin
                o_cmd.init = 1'b1;
                n_cls      = i_sts.cls;
                n_step     = 3'd0;
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else begin
                    unique case (i_sts.cls)
                        vmes_pkg::CL_FIXED: n_state = S_SLOT;
                        vmes_pkg::CL_PICK:  n_state = S_PK_RD;
                        vmes_pkg::CL_XDROP: n_state = S_MV_RD;
                        vmes_pkg::CL_ROLL:  n_state = S_RL_RD;
                        vmes_pkg::CL_REV:   n_state = S_RV_RA;
                        default:            n_state = S_FIN;
                    endcase
                end
            end
            S_SLOT: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_sel = vmes_pkg::WR_SLOT;
                o_cmd.step   = r_step;
                if (r_step == 3'd4) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_PK_RD: begin
                o_cmd.rd_sel = vmes_pkg::RD_IDX;
                n_state      = S_PK_WR;
            end
            S_PK_WR: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_sel = vmes_pkg::WR_PICK;
                n_state      = S_FIN;
            end
            S_RL_RD: begin
                o_cmd.rd_sel = vmes_pkg::RD_IDX;
                n_state      = S_RL_CAP;
            end
            S_RL_CAP: begin
                o_cmd.cap_tmp = 1'b1;
                n_state       = S_MV_RD;
            end
            S_MV_RD: begin
                if (i_sts.mv_done) begin
                    n_state = (r_cls == vmes_pkg::CL_ROLL) ? S_RL_WR : S_FIN;
                end else begin
                    o_cmd.rd_sel = vmes_pkg::RD_PNEXT;
                    n_state      = S_MV_WR;
                end
            end
            S_MV_WR: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_sel  = vmes_pkg::WR_MOVE;
                o_cmd.mv_step = 1'b1;
                n_state       = S_MV_RD;
            end
            S_RL_WR: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_sel = vmes_pkg::WR_ROLL;
                n_state      = S_FIN;
            end
            S_RV_RA: begin
                if (i_sts.rev_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_sel = vmes_pkg::RD_LO;
                    n_state      = S_RV_RB;
                end
            end
            S_RV_RB: begin
                o_cmd.rd_sel  = vmes_pkg::RD_HI;
                o_cmd.cap_tmp = 1'b1;
                n_state       = S_RV_WA;
            end
            S_RV_WA: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_sel = vmes_pkg::WR_LO;
                n_state      = S_RV_WB;
            end
            S_RV_WB: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_sel  = vmes_pkg::WR_HI;
                o_cmd.rv_step = 1'b1;
                n_state       = S_RV_RA;
            end
            S_FIN: begin
                o_cmd.commit = 1'b1;
                o_cmd.rd_sel = vmes_pkg::RD_TOP;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_LOAD))
        else $error("accepted item did not start loading");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !o_cmd.we)
        else $error("memory write while idle");

endmodule

/* src/vmes_dp.sv */
// Datapath of the evaluation stack unit: word memory, count, limit, operand
// registers and error checks. Depends on vmes_pkg and vmes_ram.
module vmes_dp #(
    parameter int STACK_DEPTH = vmes_pkg::STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vmes_pkg::t_cmd       i_cmd,
    input  logic [3:0]           i_func,
    input  logic signed [63:0]   i_push_value,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_wdata,
    output vmes_pkg::t_sts       o_sts,
    output logic [2:0]           o_status,
    output logic [8:0]           o_depth_after,
    output logic signed [63:0]   o_top_word,
    output logic                 o_top_valid
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    vmes_pkg::t_func   r_func;
    logic [63:0]       r_pv;
    logic [CW-1:0]     r_cnt, r_cnt_nx;
    logic [8:0]        r_limit;
    logic [63:0]       r_w [4];
    logic [63:0]       r_tmp;
    logic [CW-1:0]     r_p, r_idx, r_lo, r_hp;
    vmes_pkg::t_status r_status;

    logic [63:0]       ram_q;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic [63:0]       ram_wdata;
    logic              ram_we;

    // opcode check, evaluated in the check step
    logic [CW-1:0]     rem, n_lo, idx, cnt_new;
    logic [63:0]       n_full;
    logic              under, ovf, grow, indexed, trivial, range_bad;
    vmes_pkg::t_status st;
    vmes_pkg::t_cls    cls;
    vmes_pkg::t_src    src;
    logic [CW-1:0]     raddr_c, waddr_c;

    always_comb begin
        rem     = r_cnt - CW'(1);
        n_full  = r_w[0];
        n_lo    = n_full[CW-1:0];
        idx     = r_cnt - CW'(2) - n_lo;
        under   = (r_cnt < CW'(vmes_pkg::need_cnt(r_func)));
        ovf     = (32'(r_cnt) >= 32'(r_limit)) || (32'(r_cnt) >= 32'(STACK_DEPTH));
        grow    = (r_func == vmes_pkg::F_PUSH) || (r_func == vmes_pkg::F_DEPTH)
               || (r_func == vmes_pkg::F_DUP) || (r_func == vmes_pkg::F_OVER)
               || (r_func == vmes_pkg::F_TUCK);
        indexed = (r_func == vmes_pkg::F_XDROP) || (r_func == vmes_pkg::F_PICK)
               || (r_func == vmes_pkg::F_ROLL) || (r_func == vmes_pkg::F_REVN);
        trivial = ((r_func == vmes_pkg::F_ROLL) && (n_full == 64'd0))
               || ((r_func == vmes_pkg::F_REVN) && (n_full <= 64'd1));
        range_bad = (r_func == vmes_pkg::F_REVN) ? (n_full > 64'(rem))
                                                 : (n_full >= 64'(rem));
        priority if (under)                             st = vmes_pkg::ST_UNDER;
        else if (indexed && n_full[63])                 st = vmes_pkg::ST_NEG;
        else if (indexed && !trivial && range_bad)      st = vmes_pkg::ST_RANGE;
        else if (grow && ovf)                           st = vmes_pkg::ST_OVER;
        else                                            st = vmes_pkg::ST_OK;

        unique case (r_func)
            vmes_pkg::F_XDROP: cls = vmes_pkg::CL_XDROP;
            vmes_pkg::F_PICK:  cls = vmes_pkg::CL_PICK;
            vmes_pkg::F_ROLL:  cls = vmes_pkg::CL_ROLL;
            vmes_pkg::F_REVN:  cls = vmes_pkg::CL_REV;
            default:           cls = vmes_pkg::CL_FIXED;
        endcase

        if (grow) begin
            cnt_new = r_cnt + CW'(1);
        end else begin
            unique case (r_func)
                vmes_pkg::F_DROP, vmes_pkg::F_NIP,
                vmes_pkg::F_ROLL, vmes_pkg::F_REVN: cnt_new = rem;
                vmes_pkg::F_XDROP:                  cnt_new = r_cnt - CW'(2);
                vmes_pkg::F_CLEAR:                  cnt_new = '0;
                default:                            cnt_new = r_cnt;
            endcase
        end
    end

    assign o_sts.err      = (st != vmes_pkg::ST_OK);
    assign o_sts.cls      = cls;
    assign o_sts.mv_done  = ((r_p + CW'(1)) == rem);
    assign o_sts.rev_done = ((r_lo + CW'(1)) >= r_hp);

    // memory address and data selection
    always_comb begin
        src = vmes_pkg::slot_src(r_func, i_cmd.step);
        unique case (i_cmd.rd_sel)
            vmes_pkg::RD_LOAD:  raddr_c = r_cnt - CW'(1) - CW'(i_cmd.step);
            vmes_pkg::RD_IDX:   raddr_c = r_idx;
            vmes_pkg::RD_PNEXT: raddr_c = r_p + CW'(1);
            vmes_pkg::RD_LO:    raddr_c = r_lo;
            vmes_pkg::RD_HI:    raddr_c = r_hp - CW'(1);
            vmes_pkg::RD_TOP:   raddr_c = r_cnt_nx - CW'(1);
            default:            raddr_c = r_cnt;
        endcase

        ram_we    = i_cmd.we;
        ram_wdata = ram_q;
        unique case (i_cmd.wr_sel)
            vmes_pkg::WR_SLOT: begin
                waddr_c = r_cnt - CW'(4) + CW'(i_cmd.step);
                ram_we  = i_cmd.we && (src != vmes_pkg::SRC_NONE);
                unique case (src)
                    vmes_pkg::SRC_PV:  ram_wdata = r_pv;
                    vmes_pkg::SRC_CNT: ram_wdata = 64'(r_cnt);
                    vmes_pkg::SRC_W0:  ram_wdata = r_w[0];
                    vmes_pkg::SRC_W1:  ram_wdata = r_w[1];
                    vmes_pkg::SRC_W2:  ram_wdata = r_w[2];
                    vmes_pkg::SRC_W3:  ram_wdata = r_w[3];
                    default:           ram_wdata = r_pv;
                endcase
            end
            vmes_pkg::WR_PICK: waddr_c = rem;
            vmes_pkg::WR_MOVE: waddr_c = r_p;
            vmes_pkg::WR_ROLL: begin
                waddr_c   = r_cnt - CW'(2);
                ram_wdata = r_tmp;
            end
            vmes_pkg::WR_LO:   waddr_c = r_lo;
            vmes_pkg::WR_HI: begin
                waddr_c   = r_hp - CW'(1);
                ram_wdata = r_tmp;
            end
            default:           waddr_c = r_cnt;
        endcase
        ram_raddr = raddr_c[AW-1:0];
        ram_waddr = waddr_c[AW-1:0];
    end

    vmes_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_cnt_nx <= '0;
            r_limit  <= vmes_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.init) begin
                r_cnt_nx <= (st != vmes_pkg::ST_OK) ? r_cnt : cnt_new;
            end
            if (i_cmd.commit) begin
                r_cnt <= r_cnt_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= vmes_pkg::t_func'(i_func);
            r_pv   <= i_push_value;
        end
        if (i_cmd.cap_w) begin
            r_w[2'(i_cmd.step - 3'd1)] <= ram_q;
        end
        if (i_cmd.cap_tmp) begin
            r_tmp <= ram_q;
        end
        if (i_cmd.init) begin
            r_status <= st;
            r_idx    <= idx;
            r_p      <= idx;
            r_lo     <= rem - n_lo;
            r_hp     <= rem;
        end
        if (i_cmd.mv_step) begin
            r_p <= r_p + CW'(1);
        end
        if (i_cmd.rv_step) begin
            r_lo <= r_lo + CW'(1);
            r_hp <= r_hp - CW'(1);
        end
    end

    assign o_status      = r_status;
    assign o_depth_after = 9'(r_cnt);
    assign o_top_valid   = (r_cnt != '0);
    assign o_top_word    = (r_cnt != '0) ? ram_q : 64'sd0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_commit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.commit) |-> $stable(r_cnt))
        else $error("count changed outside commit");

endmodule

/* src/vm_evaluation_stack_unit.sv */
// Top level of the evaluation stack unit: sequencer plus datapath.
// Depends on vmes_pkg, vmes_ctrl, vmes_dp (which holds vmes_ram).
//
// Usage: raise start with i_func and i_push_value while busy is low; the
// item is taken at that edge and busy stays high until the result is out.
// The result (o_status, o_depth_after, o_top_word, o_top_valid) is shown
// for exactly one cycle with o_valid; the receiver cannot hold it off.
// Steps per item, from the start cycle through the o_valid cycle:
//   fixed-shape opcodes: 4-word load, check, 5 write slots, top-word read;
//     any error goes from the check straight to the top-word read;
//   PICK: one indexed read and one write after the check;
//   XDROP, ROLL: one read and one write per moved word on the single memory
//     port pair, ROLL with an indexed read and a final write around them;
//   REVERSEN: two reads, two writes per swap.
// One item is in flight at a time; the next start is taken the cycle after
// o_valid. i_cfg_we writes the stack limit (reset 256). Reset empties the
// stack at once; there is no clearing pass, words above the count are never
// used.
module vm_evaluation_stack_unit #(
    parameter int STACK_DEPTH = vmes_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          i_func,
    input  logic signed [63:0]  i_push_value,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [8:0]          o_depth_after,
    output logic signed [63:0]  o_top_word,
    output logic                o_top_valid
);

    vmes_pkg::t_cmd cmd;
    vmes_pkg::t_sts sts;

    vmes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    vmes_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_depth_after (o_depth_after),
        .o_top_word    (o_top_word),
        .o_top_valid   (o_top_valid)
    );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for vm_evaluation_stack_unit: start/busy driver, result monitor.
// Depends on vmes_pkg and the RTL of vm_evaluation_stack_unit.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        vmes_pkg::t_status status;
        logic [8:0]  depth;
        logic [63:0] top;
        logic        top_valid;
    } t_stack_view;

    typedef struct {
        vmes_pkg::t_func func;
        logic [63:0] value;
        t_stack_view view;
    } t_stack_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_func = '0;
    logic signed [63:0] i_push_value = '0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [8:0]  o_depth_after;
    logic signed [63:0] o_top_word;
    logic        o_top_valid;

    vm_evaluation_stack_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_push_value(i_push_value),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_status(o_status), .o_depth_after(o_depth_after),
        .o_top_word(o_top_word), .o_top_valid(o_top_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow stack, advanced as ops are queued (ops run strictly in order)
    logic [63:0] shadow_words [0:255];
    int          shadow_count = 0;
    int          shadow_limit = 256;

    t_stack_op   pending_ops[$];
    t_stack_view views_due[$];
    t_stack_op   cur_op;
    int          ops_taken = 0;
    int          views_seen = 0;
    int          errors = 0;
    int          cycles = 0;
    bit          no_gaps = 1'b0;

    function automatic void stack_move_down(int lo, int n);
        for (int k = 0; k < n; k++) shadow_words[lo + k] = shadow_words[lo + k + 1];
    endfunction

    function automatic void stack_reverse(int lo, int hi);
        logic [63:0] t;
        while (lo < hi) begin
            t = shadow_words[lo];
            shadow_words[lo] = shadow_words[hi];
            shadow_words[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    function automatic t_stack_view stack_exec(vmes_pkg::t_func f, logic [63:0] pv);
        t_stack_view v;
        int c, lim, rem, idx, need;
        logic [63:0] n, a, b;
        c = shadow_count;
        lim = (shadow_limit < 256) ? shadow_limit : 256;
        v.status = vmes_pkg::ST_OK;
        case (f)
            vmes_pkg::F_PUSH, vmes_pkg::F_DEPTH, vmes_pkg::F_DUP, vmes_pkg::F_OVER,
            vmes_pkg::F_TUCK: begin
                need = (f == vmes_pkg::F_OVER || f == vmes_pkg::F_TUCK) ? 2
                     : (f == vmes_pkg::F_DUP ? 1 : 0);
                if (c < need) v.status = vmes_pkg::ST_UNDER;
                else if (c >= lim) v.status = vmes_pkg::ST_OVER;
                else begin
                    case (f)
                        vmes_pkg::F_PUSH:  shadow_words[c] = pv;
                        vmes_pkg::F_DEPTH: shadow_words[c] = 64'(c);
                        vmes_pkg::F_DUP:   shadow_words[c] = shadow_words[c-1];
                        vmes_pkg::F_OVER:  shadow_words[c] = shadow_words[c-2];
                        default: begin
                            a = shadow_words[c-2];
                            b = shadow_words[c-1];
                            shadow_words[c-2] = b;
                            shadow_words[c-1] = a;
                            shadow_words[c] = b;
                        end
                    endcase
                    shadow_count = c + 1;
                end
            end
            vmes_pkg::F_DROP: begin
                if (c < 1) v.status = vmes_pkg::ST_UNDER;
                else shadow_count = c - 1;
            end
            vmes_pkg::F_NIP: begin
                if (c < 2) v.status = vmes_pkg::ST_UNDER;
                else begin
                    shadow_words[c-2] = shadow_words[c-1];
                    shadow_count = c - 1;
                end
            end
            vmes_pkg::F_CLEAR: shadow_count = 0;
            vmes_pkg::F_SWAP: begin
                if (c < 2) v.status = vmes_pkg::ST_UNDER;
                else stack_reverse(c - 2, c - 1);
            end
            vmes_pkg::F_ROT: begin
                if (c < 3) v.status = vmes_pkg::ST_UNDER;
                else begin
                    a = shadow_words[c-3];
                    stack_move_down(c - 3, 2);
                    shadow_words[c-1] = a;
                end
            end
            vmes_pkg::F_REV3: begin
                if (c < 3) v.status = vmes_pkg::ST_UNDER;
                else stack_reverse(c - 3, c - 1);
            end
            vmes_pkg::F_REV4: begin
                if (c < 4) v.status = vmes_pkg::ST_UNDER;
                else stack_reverse(c - 4, c - 1);
            end
            default: begin
                // indexed ops: index word comes off the top first
                if (c == 0) v.status = vmes_pkg::ST_UNDER;
                else begin
                    n = shadow_words[c-1];
                    rem = c - 1;
                    if (n[63]) v.status = vmes_pkg::ST_NEG;
                    else if ((f == vmes_pkg::F_ROLL && n == 0)
                             || (f == vmes_pkg::F_REVN && n <= 1))
                        shadow_count = rem;
                    else if (f == vmes_pkg::F_REVN ? (n > 64'(rem)) : (n >= 64'(rem)))
                        v.status = vmes_pkg::ST_RANGE;
                    else if (f == vmes_pkg::F_REVN) begin
                        stack_reverse(rem - int'(n), rem - 1);
                        shadow_count = rem;
                    end else begin
                        idx = rem - 1 - int'(n);
                        if (f == vmes_pkg::F_PICK) shadow_words[rem] = shadow_words[idx];
                        else if (f == vmes_pkg::F_XDROP) begin
                            stack_move_down(idx, int'(n));
                            shadow_count = rem - 1;
                        end else begin
                            a = shadow_words[idx];
                            stack_move_down(idx, int'(n));
                            shadow_words[rem-1] = a;
                            shadow_count = rem;
                        end
                    end
                end
            end
        endcase
        v.depth = 9'(shadow_count);
        v.top_valid = (shadow_count > 0);
        v.top = v.top_valid ? shadow_words[shadow_count-1] : 64'd0;
        return v;
    endfunction

    function automatic void queue_op(vmes_pkg::t_func f, logic [63:0] pv);
        t_stack_op op;
        op.func = f;
        op.value = pv;
        op.view = stack_exec(f, pv);
        pending_ops = {pending_ops, op};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic vmes_pkg::t_func rand_indexed();
        case ($urandom_range(0, 3))
            0: return vmes_pkg::F_XDROP;
            1: return vmes_pkg::F_PICK;
            2: return vmes_pkg::F_ROLL;
            default: return vmes_pkg::F_REVN;
        endcase
    endfunction

    // mostly well-formed: index pushed just before the indexed op
    function automatic void queue_random_op();
        int r;
        logic [63:0] pv;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            pv = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 9)) : rand_word();
            queue_op(vmes_pkg::F_PUSH, pv);
        end else if (r < 65) begin
            queue_op(vmes_pkg::F_PUSH, 64'($urandom_range(0, shadow_count + 1)));
            queue_op(rand_indexed(), 64'd0);
        end else if (r < 70) begin
            queue_op(vmes_pkg::F_PUSH, {1'b1, 63'(rand_word())});
            queue_op(rand_indexed(), rand_word());
        end else if (r < 72) begin
            queue_op(vmes_pkg::F_CLEAR, rand_word());
        end else begin
            queue_op(vmes_pkg::t_func'($urandom_range(0, 15)), rand_word());
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                views_due = {views_due, cur_op.view};
                ops_taken++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_ops.size() > 0
                         && (no_gaps || $urandom_range(0, 99) >= 37)) begin
                cur_op = pending_ops.pop_front();
                start <= 1'b1;
                i_func <= cur_op.func;
                i_push_value <= cur_op.value;
            end else begin
                start <= 1'b0;
                i_func <= 4'($urandom);
                i_push_value <= rand_word();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_stack_view e;
        if (i_rst_n && o_valid) begin
            views_seen++;
            if (views_due.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d depth %0d top %h",
                         $time, o_status, o_depth_after, o_top_word);
                errors++;
            end else begin
                e = views_due.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_depth_after !== e.depth) begin
                    $display("%0t: depth exp %0d got %0d", $time, e.depth, o_depth_after);
                    errors++;
                end
                if (o_top_word !== e.top) begin
                    $display("%0t: top exp %h got %h", $time, e.top, o_top_word);
                    errors++;
                end
                if (o_top_valid !== e.top_valid) begin
                    $display("%0t: top_valid exp %0d got %0d", $time, e.top_valid,
                             o_top_valid);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // checked between edges so that the driver's updates have settled
    task automatic drain();
        while (pending_ops.size() > 0 || start || busy || views_due.size() > 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 9'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_limit = value;
    endtask

    int limits[8] = '{4, 1, 0, 511, 300, 20, 256, 2};

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-stack underflow, extremes, every opcode, index corners
        for (int f = 2; f <= 15; f++)
            if (f != 5) queue_op(vmes_pkg::t_func'(f), 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'h8000_0000_0000_0000);
        queue_op(vmes_pkg::F_PUSH, 64'h7fff_ffff_ffff_ffff);
        queue_op(vmes_pkg::F_PUSH, '1);
        queue_op(vmes_pkg::F_DEPTH, 64'd0);
        queue_op(vmes_pkg::F_DUP, 64'd0);
        queue_op(vmes_pkg::F_OVER, 64'd0);
        queue_op(vmes_pkg::F_TUCK, 64'd0);
        queue_op(vmes_pkg::F_SWAP, 64'd0);
        queue_op(vmes_pkg::F_ROT, 64'd0);
        queue_op(vmes_pkg::F_REV3, 64'd0);
        queue_op(vmes_pkg::F_REV4, 64'd0);
        queue_op(vmes_pkg::F_NIP, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd2);   queue_op(vmes_pkg::F_PICK, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd1);   queue_op(vmes_pkg::F_ROLL, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd3);   queue_op(vmes_pkg::F_REVN, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd2);   queue_op(vmes_pkg::F_XDROP, 64'd0);
        queue_op(vmes_pkg::F_PUSH, '1);      queue_op(vmes_pkg::F_XDROP, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd100); queue_op(vmes_pkg::F_PICK, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd0);   queue_op(vmes_pkg::F_ROLL, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd1);   queue_op(vmes_pkg::F_REVN, 64'd0);
        queue_op(vmes_pkg::F_PUSH, 64'd0);   queue_op(vmes_pkg::F_REVN, 64'd0);
        queue_op(vmes_pkg::F_CLEAR, 64'd0);
        drain();

        foreach (limits[p]) begin
            set_limit(limits[p]);
            // for limits 511 and 256, fill past the 256-word depth so overflow and deep moves are hit
            if (p == 3 || p == 6)
                repeat (262) queue_op(vmes_pkg::F_PUSH, rand_word());
            no_gaps = (p == 4);
            repeat (75) queue_random_op();
            if (p == 4) queue_op(vmes_pkg::F_CLEAR, 64'd0);
            drain();
            no_gaps = 1'b0;
        end

        repeat (600) @(posedge i_clk);
        $display("Covered %0d ops and %0d results over %0d stack limits, reset one included",
                 ops_taken, views_seen, 9);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
